/* design/sacl_pkg.sv */
// Package: shared types, constants and helpers for the set-associative tag lookup.
`timescale 1ns / 1ps
package sacl_pkg;

    localparam int SET_BITS_DEF  = 10;
    localparam int WAY_BITS_DEF  = 3;
    localparam int ADDR_BITS_DEF = 48;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;

    localparam logic [1:0] REG_OFFSET_BITS    = 2'd0;
    localparam logic [1:0] REG_INDEX_BITS     = 2'd1;
    localparam logic [1:0] REG_WAY_BITS       = 2'd2;
    localparam logic [1:0] REG_REPLACE_RANDOM = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic update;
    } ctrl_t;

    typedef struct packed {
        logic clear_done;
    } status_t;

    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        logic b;
        b = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {b, s[15:1]};
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

/* design/sacl_ctrl.sv */
// Controller: reset clearing pass, then a read state and a write-back state per access.
`timescale 1ns / 1ps
module sacl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output sacl_pkg::ctrl_t   ctrl,
    input  sacl_pkg::status_t status
);

    sacl_pkg::state_t state_reg;
    sacl_pkg::state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sacl_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sacl_pkg::ST_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = sacl_pkg::ST_IDLE;
                end
            end
            sacl_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = sacl_pkg::ST_READ;
                end
            end
            sacl_pkg::ST_READ:  state_next = sacl_pkg::ST_WRITE;
            sacl_pkg::ST_WRITE: state_next = sacl_pkg::ST_IDLE;
            default:            state_next = sacl_pkg::ST_IDLE;
        endcase
    end

    // Drive commands
    always_comb
    begin
        busy            = 1'b1;
        ctrl.clear_step = 1'b0;
        ctrl.capture    = 1'b0;
        ctrl.update     = 1'b0;
        case (state_reg)
            sacl_pkg::ST_CLEAR: ctrl.clear_step = 1'b1;
            sacl_pkg::ST_IDLE:
            begin
                busy         = 1'b0;
                ctrl.capture = start;
            end
            sacl_pkg::ST_READ:  busy = 1'b1;
            sacl_pkg::ST_WRITE: ctrl.update = 1'b1;
            default:            busy = 1'b1;
        endcase
    end

endmodule

/* design/sacl_datapath.sv */
// Datapath: set memory, hit and victim logic, LFSR and access counters.
`timescale 1ns / 1ps
module sacl_datapath #(
    parameter int SET_BITS  = sacl_pkg::SET_BITS_DEF,
    parameter int WAY_BITS  = sacl_pkg::WAY_BITS_DEF,
    parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sacl_pkg::ctrl_t      ctrl,
    output sacl_pkg::status_t    status,
    input  logic [ADDR_BITS-1:0] address,
    input  logic                 mode,
    input  logic [4:0]           offset_bits,
    input  logic [3:0]           index_bits,
    input  logic [1:0]           way_bits,
    input  logic                 replace_random,
    output logic                 done,
    output logic                 hit,
    output logic                 filled_free_way,
    output logic [9:0]           set_index,
    output logic [2:0]           way_index,
    output logic [31:0]          read_accesses,
    output logic [31:0]          read_misses,
    output logic [31:0]          write_accesses,
    output logic [31:0]          write_misses
);

    localparam int WAYS = 1 << WAY_BITS;
    localparam int SETS = 1 << SET_BITS;
    localparam int SW   = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WW   = (WAY_BITS > 0) ? WAY_BITS : 1;
    localparam int RW   = WW;
    localparam logic [RW-1:0] RANK_MAX = RW'(WAYS - 1);

    typedef struct packed {
        logic                 valid;
        logic [RW-1:0]        rank;
        logic [ADDR_BITS-1:0] tag;
    } line_t;

    typedef line_t [WAYS-1:0] row_t;

    // One row per set, holding every way
    row_t set_mem [SETS];

    row_t                 row_reg;
    logic [SW-1:0]        set_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic                 mode_reg;
    logic [SW:0]          clr_reg;
    logic [15:0]          lfsr_reg;
    logic [31:0]          rd_acc_reg, rd_mis_reg, wr_acc_reg, wr_mis_reg;

    // Effective geometry
    logic [4:0]           ib_eff;
    logic [2:0]           wb_eff;
    logic [ADDR_BITS-1:0] set_full;
    logic [SW-1:0]        set_sel;
    logic [ADDR_BITS-1:0] tag_sel;
    logic [6:0]           tshift;

    always_comb
    begin
        ib_eff   = (5'(index_bits) > 5'(SET_BITS)) ? 5'(SET_BITS) : 5'(index_bits);
        wb_eff   = (3'(way_bits) > 3'(WAY_BITS)) ? 3'(WAY_BITS) : 3'(way_bits);
        set_full = (address >> offset_bits) & ((ADDR_BITS'(1) << ib_eff) - ADDR_BITS'(1));
        set_sel  = SW'(set_full);
        tshift   = 7'(offset_bits) + 7'(ib_eff);
        tag_sel  = (tshift >= 7'(ADDR_BITS)) ? '0 : (address >> tshift);
    end

    // Clearing pass and access capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (ctrl.clear_step && !clr_reg[SW])
        begin
            clr_reg <= clr_reg + (SW+1)'(1);
        end
    end
    assign status.clear_done = clr_reg[SW] || (SET_BITS == 0 && clr_reg[0]);

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            set_reg  <= set_sel;
            tag_reg  <= tag_sel;
            mode_reg <= mode;
        end
    end

    // Lookup on the registered row
    logic [WAYS-1:0] in_use, match, free;
    logic            hit_c, free_c;
    logic [WW-1:0]   hit_w, free_w, lru_w, vict_w, way_c;
    logic [RW-1:0]   best;
    logic [15:0]     lfsr_n;
    logic [WW-1:0]   way_mask;
    row_t            row_new;

    always_comb
    begin
        way_mask = WW'((1 << wb_eff) - 1);
        hit_c = 1'b0; free_c = 1'b0;
        hit_w = '0; free_w = '0; lru_w = '0;
        best  = row_reg[0].rank;
        for (int i = 0; i < WAYS; i++)
        begin
            in_use[i] = (i < (1 << wb_eff));
            match[i]  = in_use[i] && row_reg[i].valid && (row_reg[i].tag == tag_reg);
            free[i]   = in_use[i] && !row_reg[i].valid;
        end
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (match[i]) begin hit_c = 1'b1; hit_w = WW'(i); end
            if (free[i])  begin free_c = 1'b1; free_w = WW'(i); end
        end
        for (int i = 1; i < WAYS; i++)
        begin
            if (in_use[i] && row_reg[i].rank > best)
            begin
                best  = row_reg[i].rank;
                lru_w = WW'(i);
            end
        end
        lfsr_n = sacl_pkg::lfsr_next(lfsr_reg);
        vict_w = replace_random ? (WW'(lfsr_n) & way_mask) : lru_w;
        way_c  = hit_c ? hit_w : (free_c ? free_w : vict_w);
        row_new = row_reg;
        for (int i = 0; i < WAYS; i++)
        begin
            if (WW'(i) != way_c && row_reg[i].valid && in_use[i])
            begin
                if ((free_c && !hit_c) || row_reg[i].rank < row_reg[way_c].rank)
                begin
                    if (row_reg[i].rank < RANK_MAX)
                    begin
                        row_new[i].rank = row_reg[i].rank + RW'(1);
                    end
                end
            end
        end
        row_new[way_c].rank = '0;
        if (!hit_c)
        begin
            row_new[way_c].valid = 1'b1;
            row_new[way_c].tag   = tag_reg;
        end
    end

    // Memory: the row of the selected set is registered each cycle and written back in the write state
    always_ff @(posedge clk)
    begin
        if (ctrl.clear_step && !clr_reg[SW])
        begin
            set_mem[SW'(clr_reg)] <= '0;
        end
        else if (ctrl.update)
        begin
            set_mem[set_reg] <= row_new;
        end
        row_reg <= set_mem[ctrl.capture ? set_sel : set_reg];
    end

    // Counters, LFSR and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg   <= sacl_pkg::LFSR_SEED;
            rd_acc_reg <= '0; rd_mis_reg <= '0;
            wr_acc_reg <= '0; wr_mis_reg <= '0;
            done       <= 1'b0;
        end
        else
        begin
            done <= ctrl.update;
            if (ctrl.update)
            begin
                if (!hit_c && !free_c && replace_random)
                begin
                    lfsr_reg <= lfsr_n;
                end
                if (mode_reg)
                begin
                    wr_acc_reg <= sacl_pkg::sat_inc(wr_acc_reg);
                    if (!hit_c) wr_mis_reg <= sacl_pkg::sat_inc(wr_mis_reg);
                end
                else
                begin
                    rd_acc_reg <= sacl_pkg::sat_inc(rd_acc_reg);
                    if (!hit_c) rd_mis_reg <= sacl_pkg::sat_inc(rd_mis_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.update)
        begin
            hit             <= hit_c;
            filled_free_way <= !hit_c && free_c;
            set_index       <= 10'(set_reg);
            way_index       <= (WAY_BITS > 0) ? 3'(way_c) : 3'd0;
        end
    end

    assign read_accesses  = rd_acc_reg;
    assign read_misses    = rd_mis_reg;
    assign write_accesses = wr_acc_reg;
    assign write_misses   = wr_mis_reg;

endmodule

/* design/set_assoc_cache_tag_lookup.sv */
// Top level: set-associative cache tag lookup with config registers.
// An access runs from start to done through row read, update and write-back, and the result register.
// A new access is accepted only after the last one has been written back to the set memory.
// Reset: a clearing pass zeroes every set of the set memory; busy stays high.
// Configuration writes are taken in any cycle; the receiver cannot stall results.
`timescale 1ns / 1ps
module set_assoc_cache_tag_lookup #(
    parameter int SET_BITS  = sacl_pkg::SET_BITS_DEF,
    parameter int WAY_BITS  = sacl_pkg::WAY_BITS_DEF,
    parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ADDR_BITS-1:0] address,
    input  logic                 mode,
    output logic                 done,
    output logic                 hit,
    output logic                 filled_free_way,
    output logic [9:0]           set_index,
    output logic [2:0]           way_index,
    output logic [31:0]          read_accesses,
    output logic [31:0]          read_misses,
    output logic [31:0]          write_accesses,
    output logic [31:0]          write_misses,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    sacl_pkg::ctrl_t   ctrl;
    sacl_pkg::status_t status;
    logic [4:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [1:0] way_bits_reg;
    logic       replace_random_reg;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg    <= 5'd5;
            index_bits_reg     <= 4'd6;
            way_bits_reg       <= 2'd2;
            replace_random_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sacl_pkg::REG_OFFSET_BITS:    offset_bits_reg    <= cfg_data[4:0];
                sacl_pkg::REG_INDEX_BITS:     index_bits_reg     <= cfg_data[3:0];
                sacl_pkg::REG_WAY_BITS:       way_bits_reg       <= cfg_data[1:0];
                sacl_pkg::REG_REPLACE_RANDOM: replace_random_reg <= cfg_data[0];
                default:                      replace_random_reg <= replace_random_reg;
            endcase
        end
    end

    sacl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .ctrl   (ctrl),
        .status (status)
    );

    sacl_datapath #(
        .SET_BITS  (SET_BITS),
        .WAY_BITS  (WAY_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .status          (status),
        .address         (address),
        .mode            (mode),
        .offset_bits     (offset_bits_reg),
        .index_bits      (index_bits_reg),
        .way_bits        (way_bits_reg),
        .replace_random  (replace_random_reg),
        .done            (done),
        .hit             (hit),
        .filled_free_way (filled_free_way),
        .set_index       (set_index),
        .way_index       (way_index),
        .read_accesses   (read_accesses),
        .read_misses     (read_misses),
        .write_accesses  (write_accesses),
        .write_misses    (write_misses)
    );

endmodule

/* design/sacl_checker.sv */
// Checker: port-level properties of the tag lookup, bound to the top level.
`timescale 1ns / 1ps
module sacl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        hit,
    input logic        filled_free_way,
    input logic [31:0] read_accesses,
    input logic [31:0] write_accesses
);

    // An accepted transfer is followed by done
    a_done_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done) else $error("done missing after transfer");

    // No result without a prior transfer
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3)) else $error("spurious done");

    // Hit and free fill are exclusive
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && filled_free_way)) else $error("hit with free fill");

    // Access counters change only with a result
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> ($stable(read_accesses) && $stable(write_accesses)))
        else $error("counter moved without result");

endmodule

bind set_assoc_cache_tag_lookup sacl_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .hit             (hit),
    .filled_free_way (filled_free_way),
    .read_accesses   (read_accesses),
    .write_accesses  (write_accesses)
);
